// File: sv/assert_macros.svh
// Assertion macros used by the mdm_wheel module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on clk, off during rst.
`define ASSERT_IMPLIES(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: implication");

// Next-cycle implication, checked on clk, off during rst.
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

// File: sv/mdm_pkg.sv
// Package for the mecanum drive mixer: widths, register map, reset values, types.
`timescale 1ns / 1ps
package mdm_pkg;

  localparam int VelW   = 16;
  localparam int GeoW   = 16;
  localparam int GainW  = 24;
  localparam int LimitW = 16;
  localparam int PwmW   = 16;
  localparam int TermW  = 19;
  localparam int MagW   = 17;
  localparam int ProdW  = MagW + GainW;
  localparam int AddrW  = 5;
  localparam int DataW  = 32;

  localparam logic [GeoW-1:0]   GeoReset   = 16'd16384;
  localparam logic [GainW-1:0]  GainReset  = 24'd65536;
  localparam logic [LimitW-1:0] LimitReset = 16'd16800;

  typedef enum logic [2:0] {
    REG_GEOMETRY_SUM     = 3'd0,
    REG_GAIN_FRONT_LEFT  = 3'd1,
    REG_GAIN_FRONT_RIGHT = 3'd2,
    REG_GAIN_REAR_LEFT   = 3'd3,
    REG_GAIN_REAR_RIGHT  = 3'd4,
    REG_PWM_LIMIT        = 3'd5
  } reg_index_t;

  typedef struct packed {
    logic en3;
    logic en4;
    logic vld4;
  } stage_ctrl_t;

endpackage

// File: sv/mdm_cmd_if.sv
// Velocity command channel: valid, ready and the three body velocity fields.
`timescale 1ns / 1ps
interface mdm_cmd_if;
  logic                     valid;
  logic                     ready;
  logic signed [mdm_pkg::VelW-1:0] vel_x;
  logic signed [mdm_pkg::VelW-1:0] vel_y;
  logic signed [mdm_pkg::VelW-1:0] yaw_rate;

  modport source (output valid, output vel_x, output vel_y, output yaw_rate, input ready);
  modport sink   (input valid, input vel_x, input vel_y, input yaw_rate, output ready);
endinterface

// File: sv/mdm_pwm_if.sv
// Bridge compare channel: valid, ready and the eight compare values.
`timescale 1ns / 1ps
interface mdm_pwm_if;
  logic                      valid;
  logic                      ready;
  logic [mdm_pkg::PwmW-1:0]  fl_chan_a;
  logic [mdm_pkg::PwmW-1:0]  fl_chan_b;
  logic [mdm_pkg::PwmW-1:0]  fr_chan_a;
  logic [mdm_pkg::PwmW-1:0]  fr_chan_b;
  logic [mdm_pkg::PwmW-1:0]  rl_chan_a;
  logic [mdm_pkg::PwmW-1:0]  rl_chan_b;
  logic [mdm_pkg::PwmW-1:0]  rr_chan_a;
  logic [mdm_pkg::PwmW-1:0]  rr_chan_b;

  modport source (output valid, output fl_chan_a, output fl_chan_b, output fr_chan_a,
                  output fr_chan_b, output rl_chan_a, output rl_chan_b, output rr_chan_a,
                  output rr_chan_b, input ready);
  modport sink   (input valid, input fl_chan_a, input fl_chan_b, input fr_chan_a,
                  input fr_chan_b, input rl_chan_a, input rl_chan_b, input rr_chan_a,
                  input rr_chan_b, output ready);
endinterface

// File: sv/mdm_wheel.sv
// One wheel: gain multiply stage, then shift, clamp and bridge channel split stage.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module mdm_wheel (
  input  logic                          clk,
  input  logic                          rst,
  input  mdm_pkg::stage_ctrl_t          ctrl,
  input  logic [mdm_pkg::MagW-1:0]      mag,
  input  logic                          neg,
  input  logic                          pos_on_b,
  input  logic [mdm_pkg::GainW-1:0]     gain,
  input  logic [mdm_pkg::LimitW-1:0]    limit,
  output logic [mdm_pkg::PwmW-1:0]      chan_a,
  output logic [mdm_pkg::PwmW-1:0]      chan_b
);

  localparam int ScaledW = mdm_pkg::ProdW - 16;

  logic [mdm_pkg::ProdW-1:0]  prod;
  logic                       prod_neg;
  logic [ScaledW-1:0]         scaled;
  logic [mdm_pkg::PwmW-1:0]   pwm;
  logic                       on_b;

  always_ff @(posedge clk) begin
    if (ctrl.en3) begin
      prod     <= mdm_pkg::ProdW'(mag) * mdm_pkg::ProdW'(gain);
      prod_neg <= neg;
    end
  end

  assign scaled = prod[mdm_pkg::ProdW-1:16];
  assign pwm    = (scaled > ScaledW'(limit)) ? limit : scaled[mdm_pkg::PwmW-1:0];
  assign on_b   = prod_neg != pos_on_b;

  always_ff @(posedge clk) begin
    if (ctrl.en4) begin
      chan_a <= on_b ? '0 : pwm;
      chan_b <= on_b ? pwm : '0;
    end
  end

  `ASSERT_IMPLIES(a_one_channel, ctrl.vld4, chan_a == '0 || chan_b == '0)
  `ASSERT_IMPLIES(a_within_limit, ctrl.vld4, chan_a <= limit && chan_b <= limit)
  `ASSERT_NEXT(a_stall_hold, ctrl.vld4 && !ctrl.en4, $stable(chan_a) && $stable(chan_b))

endmodule

// File: sv/mecanum_drive_mixer.sv
// Mecanum drive mixer top level: body velocity command to four H-bridge compare pairs.
//
//   channel  dir  width  contents
//   cmd      in   48     vel_x, vel_y, yaw_rate (signed Q8.8)
//   pwm      out  128    fl/fr/rl/rr chan_a, chan_b compare values
//   apb      in   32     geometry_sum, four wheel gains, pwm_limit
//
// One transfer per cycle sustained while the output is not stalled; register stages in order:
// yaw multiply, wheel terms, gain multiply, clamp and split.
// Synchronous reset clears stage valid bits and restores register reset values.
// A stalled output holds every stage that is full; empty stages keep filling.
`timescale 1ns / 1ps
module mecanum_drive_mixer (
  input  logic                        clk,
  input  logic                        rst,
  mdm_cmd_if.sink                     cmd,
  mdm_pwm_if.source                   pwm,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [mdm_pkg::AddrW-1:0]   paddr,
  input  logic [mdm_pkg::DataW-1:0]   pwdata,
  output logic [mdm_pkg::DataW-1:0]   prdata,
  output logic                        pready
);

  localparam int TW = mdm_pkg::TermW;
  localparam int MW = mdm_pkg::MagW;

  // configuration registers
  logic [mdm_pkg::GeoW-1:0]   geometry_sum;
  logic [mdm_pkg::GainW-1:0]  gain_fl;
  logic [mdm_pkg::GainW-1:0]  gain_fr;
  logic [mdm_pkg::GainW-1:0]  gain_rl;
  logic [mdm_pkg::GainW-1:0]  gain_rr;
  logic [mdm_pkg::LimitW-1:0] pwm_limit;
  logic                       wr;
  logic [2:0]                 idx;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;
  assign idx    = paddr[4:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      geometry_sum <= mdm_pkg::GeoReset;
      gain_fl      <= mdm_pkg::GainReset;
      gain_fr      <= mdm_pkg::GainReset;
      gain_rl      <= mdm_pkg::GainReset;
      gain_rr      <= mdm_pkg::GainReset;
      pwm_limit    <= mdm_pkg::LimitReset;
    end else if (wr) begin
      case (idx)
        mdm_pkg::REG_GEOMETRY_SUM:     geometry_sum <= pwdata[mdm_pkg::GeoW-1:0];
        mdm_pkg::REG_GAIN_FRONT_LEFT:  gain_fl      <= pwdata[mdm_pkg::GainW-1:0];
        mdm_pkg::REG_GAIN_FRONT_RIGHT: gain_fr      <= pwdata[mdm_pkg::GainW-1:0];
        mdm_pkg::REG_GAIN_REAR_LEFT:   gain_rl      <= pwdata[mdm_pkg::GainW-1:0];
        mdm_pkg::REG_GAIN_REAR_RIGHT:  gain_rr      <= pwdata[mdm_pkg::GainW-1:0];
        mdm_pkg::REG_PWM_LIMIT:        pwm_limit    <= pwdata[mdm_pkg::LimitW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      mdm_pkg::REG_GEOMETRY_SUM:     prdata = mdm_pkg::DataW'(geometry_sum);
      mdm_pkg::REG_GAIN_FRONT_LEFT:  prdata = mdm_pkg::DataW'(gain_fl);
      mdm_pkg::REG_GAIN_FRONT_RIGHT: prdata = mdm_pkg::DataW'(gain_fr);
      mdm_pkg::REG_GAIN_REAR_LEFT:   prdata = mdm_pkg::DataW'(gain_rl);
      mdm_pkg::REG_GAIN_REAR_RIGHT:  prdata = mdm_pkg::DataW'(gain_rr);
      mdm_pkg::REG_PWM_LIMIT:        prdata = mdm_pkg::DataW'(pwm_limit);
      default:                       prdata = '0;
    endcase
  end

  // pipeline control
  logic v1, v2, v3, v4;
  logic rdy1, rdy2, rdy3, rdy4;
  mdm_pkg::stage_ctrl_t ctrl;

  assign rdy4 = !v4 || pwm.ready;
  assign rdy3 = !v3 || rdy4;
  assign rdy2 = !v2 || rdy3;
  assign rdy1 = !v1 || rdy2;
  assign cmd.ready = rdy1;
  assign pwm.valid = v4;

  assign ctrl.en3  = rdy3 && v2;
  assign ctrl.en4  = rdy4 && v3;
  assign ctrl.vld4 = v4;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (rdy1) v1 <= cmd.valid;
      if (rdy2) v2 <= v1;
      if (rdy3) v3 <= v2;
      if (rdy4) v4 <= v3;
    end
  end

  // stage 1: yaw times geometry
  logic [mdm_pkg::VelW-1:0] x1, y1;
  logic signed [32:0]       prod1;

  always_ff @(posedge clk) begin
    if (rdy1 && cmd.valid) begin
      x1    <= cmd.vel_x;
      y1    <= cmd.vel_y;
      prod1 <= $signed({1'b0, geometry_sum}) * cmd.yaw_rate;
    end
  end

  // stage 2: wheel terms, magnitude and sign
  logic [TW-1:0] x_e, y_e, rot_e;
  logic [TW-1:0] t_fl, t_fr, t_rl, t_rr;
  logic [MW-1:0] m_fl, m_fr, m_rl, m_rr;
  logic          n_fl, n_fr, n_rl, n_rr;

  function automatic logic [MW-1:0] mag_of(input logic [TW-1:0] t);
    logic [TW-1:0] a;
    a = t[TW-1] ? (~t + TW'(1)) : t;
    return a[MW-1:0];
  endfunction

  assign x_e   = {{(TW-16){x1[15]}}, x1};
  assign y_e   = {{(TW-16){y1[15]}}, y1};
  // floor shift: arithmetic high half of the product
  assign rot_e = {{(TW-17){prod1[32]}}, prod1[32:16]};

  assign t_fl = x_e - y_e - rot_e;
  assign t_fr = x_e + y_e + rot_e;
  assign t_rl = x_e + y_e - rot_e;
  assign t_rr = x_e - y_e + rot_e;

  always_ff @(posedge clk) begin
    if (rdy2 && v1) begin
      m_fl <= mag_of(t_fl);
      m_fr <= mag_of(t_fr);
      m_rl <= mag_of(t_rl);
      m_rr <= mag_of(t_rr);
      n_fl <= t_fl[TW-1];
      n_fr <= t_fr[TW-1];
      n_rl <= t_rl[TW-1];
      n_rr <= t_rr[TW-1];
    end
  end

  // stages 3 and 4: per-wheel gain, clamp and channel split
  mdm_wheel u_fl (
    .clk(clk), .rst(rst), .ctrl(ctrl), .mag(m_fl), .neg(n_fl), .pos_on_b(1'b1),
    .gain(gain_fl), .limit(pwm_limit), .chan_a(pwm.fl_chan_a), .chan_b(pwm.fl_chan_b)
  );
  mdm_wheel u_fr (
    .clk(clk), .rst(rst), .ctrl(ctrl), .mag(m_fr), .neg(n_fr), .pos_on_b(1'b0),
    .gain(gain_fr), .limit(pwm_limit), .chan_a(pwm.fr_chan_a), .chan_b(pwm.fr_chan_b)
  );
  mdm_wheel u_rl (
    .clk(clk), .rst(rst), .ctrl(ctrl), .mag(m_rl), .neg(n_rl), .pos_on_b(1'b1),
    .gain(gain_rl), .limit(pwm_limit), .chan_a(pwm.rl_chan_a), .chan_b(pwm.rl_chan_b)
  );
  mdm_wheel u_rr (
    .clk(clk), .rst(rst), .ctrl(ctrl), .mag(m_rr), .neg(n_rr), .pos_on_b(1'b0),
    .gain(gain_rr), .limit(pwm_limit), .chan_a(pwm.rr_chan_a), .chan_b(pwm.rr_chan_b)
  );

endmodule
